// ===== rtl/core/refraction_direction_macros.svh =====
// assertion helpers for the refraction direction block
`ifndef REFRACTION_DIRECTION_MACROS_SVH
`define REFRACTION_DIRECTION_MACROS_SVH

// same-cycle implication, off while reset is low
`define RD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("refraction_direction: implication failed");

// next-cycle implication, off while reset is low
`define RD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("refraction_direction: next-cycle check failed");

// next-cycle implication that also runs during reset
`define RD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("refraction_direction: reset check failed");

`endif

// ===== rtl/core/rd_pkg.sv =====
package rd_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int VEC_W         = 16;
    localparam int IDX_W         = 15;
    localparam int THR_W         = 13;
    localparam logic [THR_W-1:0] THR_RST = 13'd1;

    localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;
    localparam logic signed [65:0] S16_MAX_W = 66'sd32767;
    localparam logic signed [65:0] S16_MIN_W = -66'sd32768;
    localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } t_vec;

    typedef struct packed {
        t_vec d;
        t_vec n;
    } t_ray;

    // what travels alongside the square root
    typedef struct packed {
        t_ray               ray;
        logic signed [31:0] ni;
        logic signed [31:0] cni;
        logic               tir;
    } t_sq_tag;

    // root width for a radicand of 31 + frac bits
    function automatic int sqrt_w(input int frac);
        return (31 + frac + 1) / 2;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN_W) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [VEC_W-1:0] sat16(input logic signed [65:0] v);
        logic signed [VEC_W-1:0] r;
        if (v > S16_MAX_W) r = 16'sh7FFF;
        else if (v < S16_MIN_W) r = 16'sh8000;
        else r = v[VEC_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/rd_ifs.sv =====
interface rd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [rd_pkg::VEC_W-1:0]  dir_x;
    logic signed [rd_pkg::VEC_W-1:0]  dir_y;
    logic signed [rd_pkg::VEC_W-1:0]  dir_z;
    logic signed [rd_pkg::VEC_W-1:0]  norm_x;
    logic signed [rd_pkg::VEC_W-1:0]  norm_y;
    logic signed [rd_pkg::VEC_W-1:0]  norm_z;
    logic        [rd_pkg::IDX_W-1:0]  rel_index;

    modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, rel_index,
                    input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, rel_index,
                    output ready);
endinterface

interface rd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rd_pkg::VEC_W-1:0]  out_x;
    logic signed [rd_pkg::VEC_W-1:0]  out_y;
    logic signed [rd_pkg::VEC_W-1:0]  out_z;
    logic                             total_internal;

    modport source (output valid, out_x, out_y, out_z, total_internal, input ready);
    modport sink   (input valid, out_x, out_y, out_z, total_internal, output ready);
endinterface

// ===== rtl/core/rd_div.sv =====
// pipelined restoring divider: 2^(2F) / divisor, one quotient bit per stage
module rd_div #(
    parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rd_pkg::IDX_W-1:0]  i_divisor,
    input  logic [TAG_W-1:0]          i_tag,
    output logic                      o_valid,
    output logic [2*FRAC_BITS:0]      o_quot,
    output logic                      o_div_zero,
    output logic [TAG_W-1:0]          o_tag
);
    localparam int QW = 2*FRAC_BITS + 1;
    localparam int RW = rd_pkg::IDX_W + 1;

    logic [QW-1:0]              r_vld;
    logic [QW-1:0]              n_vld;
    logic [RW-1:0]              r_rem  [QW];
    logic [RW-1:0]              n_rem  [QW];
    logic [QW-1:0]              r_quot [QW];
    logic [QW-1:0]              n_quot [QW];
    logic [rd_pkg::IDX_W-1:0]   r_dvs  [QW];
    logic [rd_pkg::IDX_W-1:0]   n_dvs  [QW];
    logic [TAG_W-1:0]           r_tag  [QW];
    logic [TAG_W-1:0]           n_tag  [QW];

    logic [RW-1:0]              w_rem_in  [QW];
    logic [QW-1:0]              w_quot_in [QW];

    always_comb begin
        logic [RW-1:0] trial;
        logic          ge;
        n_vld        = {r_vld[QW-2:0], i_valid};
        w_rem_in[0]  = '0;
        w_quot_in[0] = '0;
        n_dvs[0]     = i_divisor;
        n_tag[0]     = i_tag;
        for (int s = 1; s < QW; s++) begin
            w_rem_in[s]  = r_rem[s-1];
            w_quot_in[s] = r_quot[s-1];
            n_dvs[s]     = r_dvs[s-1];
            n_tag[s]     = r_tag[s-1];
        end
        for (int s = 0; s < QW; s++) begin
            // the dividend has its only set bit at the top
            trial     = {w_rem_in[s][RW-2:0], 1'(s == 0)};
            ge        = trial >= {1'b0, n_dvs[s]};
            n_rem[s]  = ge ? trial - {1'b0, n_dvs[s]} : trial;
            n_quot[s] = {w_quot_in[s][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_dvs  <= n_dvs;
            r_tag  <= n_tag;
        end
    end

    assign o_valid    = r_vld[QW-1];
    assign o_quot     = r_quot[QW-1];
    assign o_div_zero = (r_dvs[QW-1] == '0);
    assign o_tag      = r_tag[QW-1];
endmodule

// ===== rtl/core/rd_cost.sv =====
// cosine and cos^2 of the transmitted angle, six stages
module rd_cost #(
    parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2*FRAC_BITS:0]       i_quot,
    input  logic                       i_div_zero,
    input  rd_pkg::t_ray               i_ray,
    input  logic [rd_pkg::THR_W-1:0]   i_thr,
    output logic                       o_valid,
    output rd_pkg::t_ray               o_ray,
    output logic signed [31:0]         o_ni,
    output logic signed [31:0]         o_cni,
    output logic signed [31:0]         o_cost2,
    output logic                       o_tir
);
    localparam logic signed [65:0] ONE_W = 66'sd1 <<< FRAC_BITS;

    logic [5:0] r_vld;

    logic signed [31:0] r1_p0, r1_p1, r1_p2, r1_ni;
    rd_pkg::t_ray       r1_ray;
    logic signed [31:0] r2_cosi, r2_ni;
    rd_pkg::t_ray       r2_ray;
    logic signed [63:0] r3_cc, r3_nn;
    logic signed [31:0] r3_cosi, r3_ni;
    rd_pkg::t_ray       r3_ray;
    logic signed [31:0] r4_om, r4_ni2, r4_cosi, r4_ni;
    rd_pkg::t_ray       r4_ray;
    logic signed [63:0] r5_pr, r5_cn;
    logic signed [31:0] r5_ni;
    rd_pkg::t_ray       r5_ray;
    logic signed [31:0] r6_cost2, r6_cni, r6_ni;
    logic               r6_tir;
    rd_pkg::t_ray       r6_ray;

    logic signed [31:0] n1_ni, n2_cosi, n4_om, n4_ni2, n6_cost2, n6_cni;
    logic signed [65:0] w_dot;

    always_comb begin
        if (i_div_zero || ((i_quot >> 31) != '0)) n1_ni = rd_pkg::S32_MAX;
        else n1_ni = $signed(32'(i_quot));
        w_dot    = 66'(r1_p0) + 66'(r1_p1) + 66'(r1_p2);
        n2_cosi  = rd_pkg::sat32(w_dot >>> FRAC_BITS);
        n4_om    = rd_pkg::sat32(ONE_W - 66'(rd_pkg::sat32(66'(r3_cc >>> FRAC_BITS))));
        n4_ni2   = rd_pkg::sat32(66'(r3_nn >>> FRAC_BITS));
        n6_cost2 = rd_pkg::sat32(ONE_W - 66'(rd_pkg::sat32(66'(r5_pr >>> FRAC_BITS))));
        n6_cni   = rd_pkg::sat32(66'(r5_cn >>> FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p0    <= $signed(i_ray.d.x) * $signed(i_ray.n.x);
            r1_p1    <= $signed(i_ray.d.y) * $signed(i_ray.n.y);
            r1_p2    <= $signed(i_ray.d.z) * $signed(i_ray.n.z);
            r1_ni    <= n1_ni;
            r1_ray   <= i_ray;
            r2_cosi  <= n2_cosi;
            r2_ni    <= r1_ni;
            r2_ray   <= r1_ray;
            r3_cc    <= r2_cosi * r2_cosi;
            r3_nn    <= r2_ni * r2_ni;
            r3_cosi  <= r2_cosi;
            r3_ni    <= r2_ni;
            r3_ray   <= r2_ray;
            r4_om    <= n4_om;
            r4_ni2   <= n4_ni2;
            r4_cosi  <= r3_cosi;
            r4_ni    <= r3_ni;
            r4_ray   <= r3_ray;
            r5_pr    <= r4_ni2 * r4_om;
            r5_cn    <= r4_cosi * r4_ni;
            r5_ni    <= r4_ni;
            r5_ray   <= r4_ray;
            r6_cost2 <= n6_cost2;
            r6_cni   <= n6_cni;
            // signed compare, a negative value is always below the bound
            r6_tir   <= n6_cost2 < $signed(32'(i_thr));
            r6_ni    <= r5_ni;
            r6_ray   <= r5_ray;
        end
    end

    assign o_valid = r_vld[5];
    assign o_ray   = r6_ray;
    assign o_ni    = r6_ni;
    assign o_cni   = r6_cni;
    assign o_cost2 = r6_cost2;
    assign o_tir   = r6_tir;
endmodule

// ===== rtl/core/rd_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
module rd_sqrt #(
    parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [30+FRAC_BITS:0]                 i_rad,
    input  logic [TAG_W-1:0]                      i_tag,
    output logic                                  o_valid,
    output logic [rd_pkg::sqrt_w(FRAC_BITS)-1:0]  o_root,
    output logic [TAG_W-1:0]                      o_tag
);
    localparam int RTW = rd_pkg::sqrt_w(FRAC_BITS);
    localparam int SW  = 2*RTW;
    localparam int RMW = RTW + 2;

    logic [RTW-1:0]   r_vld;
    logic [RTW-1:0]   n_vld;
    logic [SW-1:0]    r_rad  [RTW];
    logic [SW-1:0]    n_rad  [RTW];
    logic [RMW-1:0]   r_rem  [RTW];
    logic [RMW-1:0]   n_rem  [RTW];
    logic [RTW-1:0]   r_root [RTW];
    logic [RTW-1:0]   n_root [RTW];
    logic [TAG_W-1:0] r_tag  [RTW];
    logic [TAG_W-1:0] n_tag  [RTW];

    logic [SW-1:0]    w_rad_in  [RTW];
    logic [RMW-1:0]   w_rem_in  [RTW];
    logic [RTW-1:0]   w_root_in [RTW];

    always_comb begin
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        logic           ge;
        n_vld        = {r_vld[RTW-2:0], i_valid};
        w_rad_in[0]  = SW'(i_rad);
        w_rem_in[0]  = '0;
        w_root_in[0] = '0;
        n_tag[0]     = i_tag;
        for (int s = 1; s < RTW; s++) begin
            w_rad_in[s]  = r_rad[s-1];
            w_rem_in[s]  = r_rem[s-1];
            w_root_in[s] = r_root[s-1];
            n_tag[s]     = r_tag[s-1];
        end
        for (int s = 0; s < RTW; s++) begin
            cur       = {w_rem_in[s][RMW-3:0], w_rad_in[s][SW-1:SW-2]};
            trial     = {w_root_in[s], 2'b01};
            ge        = cur >= trial;
            n_rem[s]  = ge ? cur - trial : cur;
            n_root[s] = {w_root_in[s][RTW-2:0], ge};
            n_rad[s]  = {w_rad_in[s][SW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_tag  <= n_tag;
        end
    end

    assign o_valid = r_vld[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_tag   = r_tag[RTW-1];
endmodule

// ===== rtl/core/rd_out.sv =====
// refracted vector assembly, three stages, the last one is the output word
module rd_out #(
    parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [rd_pkg::sqrt_w(FRAC_BITS)-1:0]  i_root,
    input  rd_pkg::t_sq_tag                       i_tag,
    output logic                                  o_valid,
    output rd_pkg::t_vec                          o_vec,
    output logic                                  o_tir
);
    logic [2:0] r_vld;

    logic signed [31:0] r1_k, r1_ni;
    rd_pkg::t_ray       r1_ray;
    logic               r1_tir;
    logic signed [47:0] r2_dp [3];
    logic signed [47:0] r2_np [3];
    logic               r2_tir;
    rd_pkg::t_vec       r3_vec;
    logic               r3_tir;

    logic signed [31:0] n1_k;
    rd_pkg::t_vec       n3_vec;
    logic signed [65:0] w_diff [3];

    always_comb begin
        n1_k = rd_pkg::sat32(66'($signed({1'b0, i_root})) + 66'(i_tag.cni));
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = 66'(r2_dp[i] >>> FRAC_BITS) - 66'(r2_np[i] >>> FRAC_BITS);
        end
        if (r2_tir) begin
            n3_vec = '0;
        end else begin
            n3_vec.x = rd_pkg::sat16(w_diff[0]);
            n3_vec.y = rd_pkg::sat16(w_diff[1]);
            n3_vec.z = rd_pkg::sat16(w_diff[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k     <= n1_k;
            r1_ni    <= i_tag.ni;
            r1_ray   <= i_tag.ray;
            r1_tir   <= i_tag.tir;
            r2_dp[0] <= $signed(r1_ray.d.x) * r1_ni;
            r2_dp[1] <= $signed(r1_ray.d.y) * r1_ni;
            r2_dp[2] <= $signed(r1_ray.d.z) * r1_ni;
            r2_np[0] <= $signed(r1_ray.n.x) * r1_k;
            r2_np[1] <= $signed(r1_ray.n.y) * r1_k;
            r2_np[2] <= $signed(r1_ray.n.z) * r1_k;
            r2_tir   <= r1_tir;
            r3_vec   <= n3_vec;
            r3_tir   <= r2_tir;
        end
    end

    assign o_valid = r_vld[2];
    assign o_vec   = r3_vec;
    assign o_tir   = r3_tir;
endmodule

// ===== rtl/core/refraction_direction.sv =====
// refraction_direction: Snell refraction of a ray direction d about a surface
// normal n with relative index eta, all signed fixed point with FRAC_BITS
// fraction bits (Q4.12 by default). Each word gives ni = 1/eta, cosi = d.n,
// cosT2 = 1 - ni^2 (1 - cosi^2) and, unless cosT2 is below reflect_threshold
// (signed compare; total internal reflection, zero vector, flag set), the
// vector d*ni - n*(sqrt(cosT2) + cosi*ni) saturated to 16 bits per component.
// Throughput is one word per clock unless the result word waits. Words pass
// through the bit-per-stage reciprocal divider, the cosine stages, the
// bit-per-stage square root and the output stages; the divider and the root
// make up most of the depth. The whole pipeline holds while the result word
// waits, so the input is ready whenever the output stage is empty or taken.
// Write reflect_threshold only while the pipeline holds no word.
module refraction_direction #(
    parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [rd_pkg::THR_W-1:0]  i_cfg_wr_data,
    rd_in_if.sink                     i_ray,
    rd_out_if.source                  o_res
);
    localparam int RAY_W = $bits(rd_pkg::t_ray);
    localparam int TAG_W = $bits(rd_pkg::t_sq_tag);
    localparam int RTW   = rd_pkg::sqrt_w(FRAC_BITS);

    // threshold register
    logic [rd_pkg::THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rd_pkg::THR_RST;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // one advance for every stage: move when the result word is gone or taken
    logic w_en;
    logic w_out_valid;

    assign w_en        = !w_out_valid || o_res.ready;
    assign i_ray.ready = w_en;

    // incoming word
    rd_pkg::t_ray w_in_ray;

    assign w_in_ray.d.x = i_ray.dir_x;
    assign w_in_ray.d.y = i_ray.dir_y;
    assign w_in_ray.d.z = i_ray.dir_z;
    assign w_in_ray.n.x = i_ray.norm_x;
    assign w_in_ray.n.y = i_ray.norm_y;
    assign w_in_ray.n.z = i_ray.norm_z;

    // reciprocal of the index, vectors ride along
    logic                 w_div_valid;
    logic [2*FRAC_BITS:0] w_quot;
    logic                 w_div_zero;
    logic [RAY_W-1:0]     w_div_tag;

    rd_div #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (RAY_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_ray.valid),
        .i_divisor  (i_ray.rel_index),
        .i_tag      (w_in_ray),
        .o_valid    (w_div_valid),
        .o_quot     (w_quot),
        .o_div_zero (w_div_zero),
        .o_tag      (w_div_tag)
    );

    // cosines and the reflection decision
    logic               w_cost_valid;
    rd_pkg::t_ray       w_cost_ray;
    logic signed [31:0] w_ni;
    logic signed [31:0] w_cni;
    logic signed [31:0] w_cost2;
    logic               w_tir;

    rd_cost #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cost (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_div_valid),
        .i_quot     (w_quot),
        .i_div_zero (w_div_zero),
        .i_ray      (w_div_tag),
        .i_thr      (r_thr),
        .o_valid    (w_cost_valid),
        .o_ray      (w_cost_ray),
        .o_ni       (w_ni),
        .o_cni      (w_cni),
        .o_cost2    (w_cost2),
        .o_tir      (w_tir)
    );

    // radicand is cosT2 scaled up by one Q unit; past the threshold it is
    // never negative, and under reflection the root is not used at all
    logic [30+FRAC_BITS:0] w_rad;
    rd_pkg::t_sq_tag       w_sq_tag_in;

    assign w_rad             = w_tir ? '0 : {w_cost2[30:0], {FRAC_BITS{1'b0}}};
    assign w_sq_tag_in.ray   = w_cost_ray;
    assign w_sq_tag_in.ni    = w_ni;
    assign w_sq_tag_in.cni   = w_cni;
    assign w_sq_tag_in.tir   = w_tir;

    logic             w_sq_valid;
    logic [RTW-1:0]   w_root;
    logic [TAG_W-1:0] w_sq_tag;

    rd_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (TAG_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cost_valid),
        .i_rad   (w_rad),
        .i_tag   (w_sq_tag_in),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_tag   (w_sq_tag)
    );

    // final vector and output word register
    rd_pkg::t_vec w_vec;
    logic         w_out_tir;

    rd_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_root  (w_root),
        .i_tag   (w_sq_tag),
        .o_valid (w_out_valid),
        .o_vec   (w_vec),
        .o_tir   (w_out_tir)
    );

    assign o_res.valid          = w_out_valid;
    assign o_res.out_x          = w_vec.x;
    assign o_res.out_y          = w_vec.y;
    assign o_res.out_z          = w_vec.z;
    assign o_res.total_internal = w_out_tir;
endmodule

// ===== rtl/core/rd_checker.sv =====
`include "refraction_direction_macros.svh"

module rd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [rd_pkg::VEC_W-1:0]   i_out_x,
    input logic signed [rd_pkg::VEC_W-1:0]   i_out_y,
    input logic signed [rd_pkg::VEC_W-1:0]   i_out_z,
    input logic                              i_out_tir
);
    logic                      w_zero_vec;
    logic [3*rd_pkg::VEC_W:0]  w_word;

    assign w_zero_vec = (i_out_x == 16'sd0) && (i_out_y == 16'sd0) && (i_out_z == 16'sd0);
    assign w_word     = {i_out_x, i_out_y, i_out_z, i_out_tir};

    // reflection gives the zero vector
    `RD_ASSERT_IMPLY(a_tir_zero, i_clk, i_rst_n, i_out_valid && i_out_tir, w_zero_vec)

    // an empty output stage never blocks the input
    `RD_ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // a waiting word stays put
    `RD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(w_word))

    // reset flushes the pipeline
    `RD_ASSERT_ALWAYS_NEXT(a_rst_flush, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind refraction_direction rd_checker u_rd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_ray.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_out_tir   (o_res.total_internal)
);
